FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: design/tdpt_pkg.sv
package tdpt_pkg;

   // Width of the item field on the port, and the width actually tested.
   localparam int NumberFieldWidth = 32;
   localparam int NumberWidth      = 32;

   // Bit counter for one serial division pass.
   localparam int CountWidth = (NumberWidth > 1) ? $clog2(NumberWidth) : 1;

   // First candidate divisor.
   localparam int FirstDivisor = 2;

endpackage

FILE: design/trial_division_prime_test_unit.sv
// Trial-division primality test. Each item carries one unsigned number and
// yields one result item, rsp_is_prime, which is 1 exactly when the low
// NumberWidth bits of the number form a prime; 0 and 1 are not prime.
// Candidate divisors run from 2 upward while the divisor does not exceed
// the quotient. A single restoring divider, one quotient bit per cycle,
// gives quotient and remainder for each candidate, followed by a check
// state that ends the item or moves on to the next candidate. Inputs
// below two try no candidate at all; the worst case for 32 bits is about
// 65536 candidates. One item is worked at a time; a new item is taken as
// soon as the previous verdict has moved into the output register, even if
// it is not yet taken.
`include "assert_macros.svh"

module trial_division_prime_test_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [tdpt_pkg::NumberFieldWidth-1:0] req_number,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_is_prime
);
   import tdpt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type               state_ff;
   logic [NumberWidth-1:0]  number_ff;
   logic [NumberWidth-1:0]  div_ff;
   logic [NumberWidth-1:0]  quot_ff;
   logic [NumberWidth-1:0]  rem_ff;
   logic [CountWidth-1:0]   count_ff;
   logic                    verdict_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_is_prime_ff;

   logic [NumberWidth-1:0]  number_in;
   logic [NumberWidth:0]    partial;
   logic                    fits;
   logic [NumberWidth-1:0]  rem_in;
   logic [NumberWidth-1:0]  quot_in;
   logic                    accept;
   logic [NumberWidth-1:0]  first_div;
   logic                    small_number;
   logic                    load_rsp;

   assign number_in = NumberWidth'(req_number);
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;
   assign first_div    = NumberWidth'(FirstDivisor);
   assign small_number = (number_in < first_div);
   // The verdict moves out when the output register is empty or being emptied.
   assign load_rsp     = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // One restoring division step: bring down the next dividend bit.
   always_comb begin
      partial = {rem_ff, quot_ff[NumberWidth-1]};
      fits    = (partial >= {1'b0, div_ff});
      rem_in  = fits ? NumberWidth'(partial - {1'b0, div_ff}) : NumberWidth'(partial);
      quot_in = {quot_ff[NumberWidth-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         rsp_is_prime_ff <= 1'b0;
         verdict_ff      <= 1'b0;
         number_ff       <= '0;
         div_ff          <= '0;
         quot_ff         <= '0;
         rem_ff          <= '0;
         count_ff        <= '0;
      end else begin
         if (load_rsp) begin
            rsp_valid_ff    <= 1'b1;
            rsp_is_prime_ff <= verdict_ff;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  number_ff <= number_in;
                  div_ff    <= first_div;
                  quot_ff   <= number_in;
                  rem_ff    <= '0;
                  count_ff  <= CountWidth'(NumberWidth - 1);
                  if (small_number) begin
                     verdict_ff <= 1'b0;
                     state_ff   <= ST_FINISH;
                  end else begin
                     state_ff <= ST_DIVIDE;
                  end
               end
            end
            ST_DIVIDE: begin
               rem_ff   <= rem_in;
               quot_ff  <= quot_in;
               count_ff <= count_ff - CountWidth'(1);
               if (count_ff == '0) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               // Past the square root with no divisor found means prime.
               if (div_ff > quot_ff) begin
                  verdict_ff <= 1'b1;
                  state_ff   <= ST_FINISH;
               end else if (rem_ff == '0) begin
                  verdict_ff <= 1'b0;
                  state_ff   <= ST_FINISH;
               end else begin
                  div_ff   <= div_ff + NumberWidth'(1);
                  quot_ff  <= number_ff;
                  rem_ff   <= '0;
                  count_ff <= CountWidth'(NumberWidth - 1);
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_FINISH: begin
               if (load_rsp) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `ASSERT_IMPLY(a_rem_below_div, clock, reset, state_ff == ST_DIVIDE, rem_ff < div_ff)
   `ASSERT_IMPLY(a_div_from_two, clock, reset, state_ff == ST_DIVIDE, div_ff >= first_div)
   `ASSERT_NEXT(a_small_not_prime, clock, reset, accept && small_number, !verdict_ff && !req_ready)

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int FieldWidth = tdpt_pkg::NumberFieldWidth;
   localparam longint unsigned WidthMask = (64'd2 << (tdpt_pkg::NumberWidth - 1)) - 64'd1;
   localparam int RandomItems = 84;
   localparam int CostCap = 512;
   localparam int BacklogCycles = 50000;
   localparam int WatchdogLimit = 200000;

   typedef struct {
      logic [FieldWidth-1:0] number;
      bit                    typed;
      bit                    verdict;
   } probe_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [FieldWidth-1:0] req_number;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_is_prime;

   bit          pending_verdicts[$];
   int unsigned verdicts_checked;
   int unsigned mismatches;
   int unsigned backlog_hold;
   int unsigned idle_cycles;
   bit          backlog_done;
   bit          steady_req;
   bit          steady_rsp;
   bit          expected_verdict;

   probe_type probes [0:15];

   trial_division_prime_test_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_prime (rsp_is_prime)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Trial division on the tested bits. The count of candidates tried lets the
   // stimulus keep away from numbers that would take the block too long.
   function automatic bit prime_verdict(input logic [FieldWidth-1:0] raw,
                                        input int unsigned cap,
                                        output int unsigned trials);
      longint unsigned n;
      longint unsigned d;
      bit verdict;
      n = 64'(raw) & WidthMask;
      trials = 0;
      verdict = (n >= 64'd2);
      d = 64'(tdpt_pkg::FirstDivisor);
      while (verdict && d <= n / d && trials <= cap) begin
         trials++;
         if (n % d == 64'd0) verdict = 1'b0;
         d++;
      end
      return verdict;
   endfunction

   // Valid is only lowered when a gap is taken, so it never drops and rises in one step.
   task automatic offer(input logic [FieldWidth-1:0] num, input bit verdict);
      if (!steady_req) begin
         while ($urandom_range(0, 99) < 10) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid  <= 1'b1;
      req_number <= num;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_verdicts.push_back(verdict);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: result %0b arrived with nothing expected", $time, rsp_is_prime);
            mismatches++;
         end else begin
            expected_verdict = pending_verdicts.pop_front();
            if (rsp_is_prime !== expected_verdict) begin
               $display("%0t: is_prime expected %0b, got %0b", $time, expected_verdict,
                        rsp_is_prime);
               mismatches++;
            end
         end
         verdicts_checked++;
         if (verdicts_checked == 30 && !backlog_done) begin
            backlog_hold = BacklogCycles;
            backlog_done = 1'b1;
         end
         steady_rsp = (verdicts_checked >= 50 && verdicts_checked < 75);
      end
      if (backlog_hold > 0) begin
         backlog_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady_rsp || ($urandom_range(0, 99) >= 10);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [FieldWidth-1:0] num;
      int unsigned trials;
      int unsigned pick;
      bit verdict;

      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_number <= '0;
      rsp_ready  <= 1'b0;
      verdicts_checked = 0;
      mismatches = 0;
      backlog_hold = 0;
      backlog_done = 1'b0;
      steady_req = 1'b0;
      steady_rsp = 1'b0;

      probes[0]  = '{32'd0,          1'b1, 1'b0};
      probes[1]  = '{32'd1,          1'b1, 1'b0};
      probes[2]  = '{32'd2,          1'b1, 1'b1};
      probes[3]  = '{32'd3,          1'b1, 1'b1};
      probes[4]  = '{32'd4,          1'b1, 1'b0};
      probes[5]  = '{32'hFFFF_FFFF,  1'b1, 1'b0};
      probes[6]  = '{32'h8000_0000,  1'b1, 1'b0};
      probes[7]  = '{32'hFFFF_FFFE,  1'b1, 1'b0};
      // Squares of primes sit exactly on the bound of the divisor loop.
      probes[8]  = '{32'd9,          1'b0, 1'b0};
      probes[9]  = '{32'd25,         1'b0, 1'b0};
      probes[10] = '{32'd63001,      1'b0, 1'b0};
      probes[11] = '{32'd5,          1'b0, 1'b0};
      probes[12] = '{32'd97,         1'b0, 1'b0};
      probes[13] = '{32'd65537,      1'b0, 1'b0};
      probes[14] = '{32'd1048573,    1'b0, 1'b0};
      probes[15] = '{32'd1000003,    1'b0, 1'b0};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i]) begin
         if (probes[i].typed) begin
            verdict = probes[i].verdict;
         end else begin
            verdict = prime_verdict(probes[i].number, 32'h0010_0000, trials);
         end
         offer(probes[i].number, verdict);
      end

      // Full-width numbers are kept only when their smallest factor is found
      // quickly; small and odd mid-sized numbers supply most of the primes.
      for (int i = 0; i < RandomItems; i++) begin
         steady_req = (i >= 45 && i < 70);
         do begin
            pick = $urandom_range(0, 9);
            if (pick < 2) num = $urandom_range(0, 65535);
            else if (pick < 4) num = $urandom_range(0, 1 << 18) | 32'd1;
            else num = $urandom;
            verdict = prime_verdict(num, CostCap, trials);
         end while (trials > CostCap);
         offer(num, verdict);
      end
      req_valid <= 1'b0;

      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
